FILE: sv/huc_pkg.sv
// Shared types, codes and character helpers for the URI character tagger.
package huc_pkg;

    // Parse phases
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_PREFIX = 3'd1;
    localparam logic [2:0] PH_HOST   = 3'd2;
    localparam logic [2:0] PH_PORT   = 3'd3;
    localparam logic [2:0] PH_PATH   = 3'd4;
    localparam logic [2:0] PH_QUERY  = 3'd5;
    localparam logic [2:0] PH_FRAG   = 3'd6;
    localparam logic [2:0] PH_DONE   = 3'd7;

    // Part tags
    localparam logic [2:0] TAG_IGN    = 3'd0;
    localparam logic [2:0] TAG_SCHEME = 3'd1;
    localparam logic [2:0] TAG_HOST   = 3'd2;
    localparam logic [2:0] TAG_PORT   = 3'd3;
    localparam logic [2:0] TAG_PATH   = 3'd4;
    localparam logic [2:0] TAG_QUERY  = 3'd5;
    localparam logic [2:0] TAG_FRAG   = 3'd6;
    localparam logic [2:0] TAG_SEP    = 3'd7;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SCHEME = 2'd1;
    localparam logic [1:0] ST_HOST   = 2'd2;
    localparam logic [1:0] ST_PORT   = 2'd3;

    // Scheme kinds
    localparam logic [1:0] SK_NONE  = 2'd0;
    localparam logic [1:0] SK_HTTP  = 2'd1;
    localparam logic [1:0] SK_HTTPS = 2'd2;

    localparam logic [15:0] PORT_HTTP  = 16'd80;
    localparam logic [15:0] PORT_HTTPS = 16'd443;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  phase;
        logic [2:0]  prefix_pos;
        logic [15:0] port_accum;
        logic [1:0]  scheme_reg;
        logic        held_slash;
        logic        query_flag;
        logic        fragment_flag;
        logic [1:0]  error_code;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:         PH_START,
        prefix_pos:    3'd0,
        port_accum:    16'd0,
        scheme_reg:    SK_NONE,
        held_slash:    1'b0,
        query_flag:    1'b0,
        fragment_flag: 1'b0,
        error_code:    ST_OK
    };

    typedef struct packed {
        logic [2:0]  part_tag;
        logic [7:0]  out_char;
        logic        summary_valid;
        logic [1:0]  status;
        logic [1:0]  scheme_kind;
        logic [15:0] port_value;
        logic        query_seen;
        logic        fragment_seen;
        logic        final_result;
    } t_result;

    function automatic logic is_term(input logic [7:0] c);
        return (c == 8'd0) || (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
    endfunction

    // Expected prefix character at a position; the plain form ends in NUL.
    function automatic logic [7:0] prefix_char(input logic secure, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'd0;
        if (secure) begin
            unique case (pos)
                3'd0: ch = "h";
                3'd1: ch = "t";
                3'd2: ch = "t";
                3'd3: ch = "p";
                3'd4: ch = "s";
                3'd5: ch = ":";
                3'd6: ch = "/";
                3'd7: ch = "/";
                default: ch = 8'd0;
            endcase
        end else begin
            unique case (pos)
                3'd0: ch = "h";
                3'd1: ch = "t";
                3'd2: ch = "t";
                3'd3: ch = "p";
                3'd4: ch = ":";
                3'd5: ch = "/";
                3'd6: ch = "/";
                default: ch = 8'd0;
            endcase
        end
        return ch;
    endfunction

endpackage

FILE: sv/huc_in_if.sv
// Input channel: one URI character or an end-of-text marker per item.
interface huc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_text;

    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

FILE: sv/huc_out_if.sv
// Result channel: one tagged character or one summary per item.
interface huc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  part_tag;
    logic [7:0]  out_char;
    logic        summary_valid;
    logic [1:0]  status;
    logic [1:0]  scheme_kind;
    logic [15:0] port_value;
    logic        query_seen;
    logic        fragment_seen;
    logic        final_result;

    modport source (
        output valid, input ready,
        output part_tag, output out_char, output summary_valid, output status,
        output scheme_kind, output port_value, output query_seen,
        output fragment_seen, output final_result
    );
    modport sink (
        input valid, output ready,
        input part_tag, input out_char, input summary_valid, input status,
        input scheme_kind, input port_value, input query_seen,
        input fragment_seen, input final_result
    );
endinterface

FILE: sv/http_uri_char_parser_core.sv
// Top level of the URI character tagger: parse state, step logic and result queue.
//
// The block takes a URI one character per item and returns, for each item, one
// result (or two) tagging the character as scheme, host, port, path, query,
// fragment, separator or ignored; host characters come out lower-cased. An
// item with end_of_text set closes the URI: it yields a summary result with
// status, scheme kind, port (explicit, else 80/443 by scheme) and query and
// fragment flags, and rearms the parser. The whole step for one item is a
// single pass of combinational logic from the parse-state register into a
// four-entry result queue, so an item is accepted every cycle while the queue
// has room for two results, and its results are registered in the queue and
// offered from its head in order. Most items cause one result; the character
// that resolves a held leading slash, and an end item that flushes a held slash,
// cause two, so a long run of such items is limited by the output side to one
// result per cycle. The result queue decouples the two sides, so input is taken
// while finished results still wait downstream.
module http_uri_char_parser_core import huc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    huc_in_if.sink    i_in,
    huc_out_if.source o_res
);

    t_state  r_state;
    t_state  n_state;
    t_result res0;
    t_result res1;
    t_result head;
    logic    two;
    logic    space;
    logic    accept;

    // Take an item whenever the queue can hold both of its possible results
    assign i_in.ready = space;
    assign accept     = i_in.valid && space;

    huc_step u_step (
        .i_state (r_state),
        .i_char  (i_in.in_char),
        .i_end   (i_in.end_of_text),
        .o_state (n_state),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_two   (two)
    );

    // Advance the parse state on every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    huc_res_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_push_two (two),
        .i_res0     (res0),
        .i_res1     (res1),
        .i_pop      (o_res.ready),
        .o_space    (space),
        .o_valid    (o_res.valid),
        .o_head     (head)
    );

    // Drive the result channel from the queue head
    assign o_res.part_tag      = head.part_tag;
    assign o_res.out_char      = head.out_char;
    assign o_res.summary_valid = head.summary_valid;
    assign o_res.status        = head.status;
    assign o_res.scheme_kind   = head.scheme_kind;
    assign o_res.port_value    = head.port_value;
    assign o_res.query_seen    = head.query_seen;
    assign o_res.fragment_seen = head.fragment_seen;
    assign o_res.final_result  = head.final_result;

endmodule

FILE: sv/huc_step.sv
// Next-state and result logic for one input item of the URI tagger.
module huc_step import huc_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_char,
    input  logic       i_end,
    output t_state     o_state,
    output t_result    o_res0,
    output t_result    o_res1,
    output logic       o_two
);

    always_comb begin
        t_state      ns;
        t_result     r0;
        t_result     r1;
        t_result     rt;
        logic        two;
        logic        done;
        logic [2:0]  ph;
        logic [2:0]  tag;
        logic [7:0]  oc;
        logic [7:0]  lc;
        logic [1:0]  st_code;
        logic [1:0]  sk;
        logic [15:0] pv;
        logic [19:0] acc;
        logic [19:0] v;
        logic [2:0]  p;
        logic        secure;
        logic [2:0]  last_pos;

        ns       = i_state;
        r0       = '0;
        r1       = '0;
        rt       = '0;
        two      = 1'b0;
        done     = 1'b0;
        ph       = i_state.phase;
        tag      = TAG_IGN;
        oc       = i_char;
        lc       = to_lower(i_char);
        st_code  = i_state.error_code;
        sk       = SK_NONE;
        pv       = 16'd0;
        acc      = {4'd0, i_state.port_accum};
        v        = (acc << 3) + (acc << 1) + {16'd0, i_char[3:0]};
        p        = i_state.prefix_pos;
        secure   = (i_state.scheme_reg == SK_HTTPS);
        last_pos = secure ? 3'd7 : 3'd6;

        if (i_end) begin
            // Flush a held slash as path, then close with the summary
            if (i_state.held_slash) begin
                r0.part_tag = TAG_PATH;
                r0.out_char = "/";
                two         = 1'b1;
            end else if (i_state.phase == PH_START || i_state.phase == PH_PREFIX) begin
                st_code = ST_SCHEME;
            end
            rt.summary_valid = 1'b1;
            rt.status        = st_code;
            rt.final_result  = 1'b1;
            if (st_code == ST_OK) begin
                sk = (i_state.scheme_reg == 2'd3) ? SK_NONE : i_state.scheme_reg;
                pv = i_state.port_accum;
                if (pv == 16'd0) begin
                    pv = (sk == SK_HTTP) ? PORT_HTTP : (sk == SK_HTTPS) ? PORT_HTTPS : 16'd0;
                end
                rt.scheme_kind   = sk;
                rt.port_value    = pv;
                rt.query_seen    = i_state.query_flag;
                rt.fragment_seen = i_state.fragment_flag;
            end
            if (two) begin
                r1 = rt;
            end else begin
                r0 = rt;
            end
            ns = STATE_RESET;
        end else begin
            // Resolve a held leading slash
            if (i_state.phase == PH_START && i_state.held_slash) begin
                ns.held_slash = 1'b0;
                two           = 1'b1;
                if (i_char == "/") begin
                    ns.phase    = PH_HOST;
                    r0.part_tag = TAG_SCHEME;
                    r0.out_char = "/";
                    r1.part_tag = TAG_SCHEME;
                    r1.out_char = i_char;
                    r1.final_result = 1'b1;
                    done        = 1'b1;
                end else begin
                    ph          = PH_PATH;
                    ns.phase    = PH_PATH;
                    r0.part_tag = TAG_PATH;
                    r0.out_char = "/";
                end
            end

            if (!done) begin
                unique case (ph)
                    PH_START: begin
                        if (i_char == "/") begin
                            ns.held_slash = 1'b1;
                        end else if (lc == "h") begin
                            ns.phase      = PH_PREFIX;
                            ns.prefix_pos = 3'd1;
                            tag           = TAG_SCHEME;
                        end else begin
                            ns.error_code = ST_SCHEME;
                            ns.phase      = PH_DONE;
                        end
                    end
                    PH_PREFIX: begin
                        if (i_state.scheme_reg == SK_NONE) begin
                            if (p < 3'd4) begin
                                if (lc != prefix_char(1'b0, p)) begin
                                    ns.error_code = ST_SCHEME;
                                    ns.phase      = PH_DONE;
                                end else begin
                                    ns.prefix_pos = p + 3'd1;
                                    tag           = TAG_SCHEME;
                                end
                            end else if (lc == ":" || lc == "s") begin
                                ns.scheme_reg = (lc == ":") ? SK_HTTP : SK_HTTPS;
                                ns.prefix_pos = 3'd5;
                                tag           = TAG_SCHEME;
                            end else begin
                                ns.error_code = ST_SCHEME;
                                ns.phase      = PH_DONE;
                            end
                        end else begin
                            if (p > last_pos || lc != prefix_char(secure, p)) begin
                                ns.error_code = ST_SCHEME;
                                ns.phase      = PH_DONE;
                            end else begin
                                if (p == last_pos) begin
                                    ns.phase = PH_HOST;
                                end else begin
                                    ns.prefix_pos = p + 3'd1;
                                end
                                tag = TAG_SCHEME;
                            end
                        end
                    end
                    PH_HOST: begin
                        if (is_term(i_char)) begin
                            ns.phase = PH_DONE;
                        end else if (i_char == ":") begin
                            ns.phase = PH_PORT;
                            tag      = TAG_SEP;
                        end else if (i_char == "/") begin
                            ns.phase = PH_PATH;
                            tag      = TAG_PATH;
                        end else if (i_char == "?") begin
                            ns.query_flag = 1'b1;
                            ns.phase      = PH_QUERY;
                            tag           = TAG_SEP;
                        end else if (i_char == "#") begin
                            ns.fragment_flag = 1'b1;
                            ns.phase         = PH_FRAG;
                            tag              = TAG_SEP;
                        end else if (is_alpha(i_char) || is_digit(i_char) ||
                                     i_char == "." || i_char == "-") begin
                            oc  = lc;
                            tag = TAG_HOST;
                        end else begin
                            ns.error_code = ST_HOST;
                            ns.phase      = PH_DONE;
                        end
                    end
                    PH_PORT: begin
                        if (is_term(i_char)) begin
                            ns.phase = PH_DONE;
                        end else if (i_char == "/") begin
                            ns.phase = PH_PATH;
                            tag      = TAG_PATH;
                        end else if (i_char == "?") begin
                            ns.query_flag = 1'b1;
                            ns.phase      = PH_QUERY;
                            tag           = TAG_SEP;
                        end else if (i_char == "#") begin
                            ns.fragment_flag = 1'b1;
                            ns.phase         = PH_FRAG;
                            tag              = TAG_SEP;
                        end else if (is_digit(i_char) && v != 20'd0 && v[19:16] == 4'd0) begin
                            ns.port_accum = v[15:0];
                            tag           = TAG_PORT;
                        end else begin
                            // Leading zero, overflow or a stray character
                            ns.error_code = ST_PORT;
                            ns.phase      = PH_DONE;
                        end
                    end
                    PH_PATH: begin
                        if (is_term(i_char)) begin
                            ns.phase = PH_DONE;
                        end else if (i_char == "?") begin
                            ns.query_flag = 1'b1;
                            ns.phase      = PH_QUERY;
                            tag           = TAG_SEP;
                        end else if (i_char == "#") begin
                            ns.fragment_flag = 1'b1;
                            ns.phase         = PH_FRAG;
                            tag              = TAG_SEP;
                        end else begin
                            tag = TAG_PATH;
                        end
                    end
                    PH_QUERY: begin
                        if (is_term(i_char)) begin
                            ns.phase = PH_DONE;
                        end else if (i_char == "#") begin
                            ns.fragment_flag = 1'b1;
                            ns.phase         = PH_FRAG;
                            tag              = TAG_SEP;
                        end else begin
                            tag = TAG_QUERY;
                        end
                    end
                    PH_FRAG: begin
                        if (is_term(i_char)) begin
                            ns.phase = PH_DONE;
                        end else begin
                            tag = TAG_FRAG;
                        end
                    end
                    default: begin
                        tag = TAG_IGN;
                    end
                endcase

                rt.part_tag     = tag;
                rt.out_char     = oc;
                rt.final_result = 1'b1;
                if (two) begin
                    r1 = rt;
                end else begin
                    r0 = rt;
                end
            end
        end

        o_state = ns;
        o_res0  = r0;
        o_res1  = r1;
        o_two   = two;
    end

endmodule

FILE: sv/huc_res_fifo.sv
// Result queue: takes one or two results per push, hands out one per cycle when popped.
module huc_res_fifo import huc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  logic    i_push_two,
    input  t_result i_res0,
    input  t_result i_res1,
    input  logic    i_pop,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_head
);

    t_result               r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   r_wr_ptr;
    logic [RQ_PTR_W-1:0]   r_rd_ptr;
    logic [RQ_CNT_W-1:0]   r_count;
    logic [RQ_PTR_W-1:0]   n_wr_ptr;
    logic [RQ_PTR_W-1:0]   n_rd_ptr;
    logic [RQ_CNT_W-1:0]   n_count;
    logic [RQ_CNT_W-1:0]   push_n;
    logic                  pop;

    assign pop     = i_pop && (r_count != '0);
    assign push_n  = !i_push ? RQ_CNT_W'(0) : (i_push_two ? RQ_CNT_W'(2) : RQ_CNT_W'(1));
    assign n_wr_ptr = r_wr_ptr + push_n[RQ_PTR_W-1:0];
    assign n_rd_ptr = r_rd_ptr + RQ_PTR_W'(pop);
    assign n_count  = r_count + push_n - RQ_CNT_W'(pop);

    // Room for the largest push
    assign o_space = (r_count <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res0;
            if (i_push_two) begin
                r_mem[r_wr_ptr + RQ_PTR_W'(1)] <= i_res1;
            end
        end
    end

endmodule
